// ===== rtl/core/agsc_pkg.sv =====
// ----------------------------------------------------------------------------
// agsc_pkg
// Shared types and constants of the gravity scale calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package agsc_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_MAG_LOW  = 2'd0;
  localparam logic [1:0] REG_MAG_HIGH = 2'd1;
  localparam logic [1:0] REG_MIN_GOOD = 2'd2;

  localparam logic [15:0] MAG_LOW_RST  = 16'd1500;
  localparam logic [15:0] MAG_HIGH_RST = 16'd30000;
  localparam logic [4:0]  MIN_GOOD_RST = 5'd8;
  localparam logic [15:0] SCALE_RST    = 16'd16384;
  localparam logic [19:0] SUM_MAX      = 20'hFFFFF;
  localparam logic [4:0]  COUNT_MAX    = 5'd31;

  // Operation codes from the controller to the datapath.
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SQRT = 2'd1,
    OP_DIV  = 2'd2,
    OP_AVG  = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    op_t  op;
    logic step;
    logic finish_calib;
    logic accum;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic ok;
    logic last_calib;
    logic busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/agsc_if.sv =====
// ----------------------------------------------------------------------------
// agsc_in_if / agsc_out_if / agsc_cfg_if
// Valid/ready channels of the gravity scale calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

interface agsc_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic               sample_ok;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_y;
  logic signed [15:0] raw_z;
  modport source (output valid, mode, sample_ok, raw_x, raw_y, raw_z, input ready);
  modport sink   (input valid, mode, sample_ok, raw_x, raw_y, raw_z, output ready);
endinterface

interface agsc_out_if;
  logic               valid;
  logic               ready;
  logic               report_kind;
  logic               read_ok;
  logic signed [15:0] x_g;
  logic signed [15:0] y_g;
  logic signed [15:0] z_g;
  logic               calib_accepted;
  logic [15:0]        scale_now;
  modport source (output valid, report_kind, read_ok, x_g, y_g, z_g, calib_accepted,
                  scale_now, input ready);
  modport sink   (input valid, report_kind, read_ok, x_g, y_g, z_g, calib_accepted,
                  scale_now, output ready);
endinterface

interface agsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/agsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// agsc_ctrl
// Sequencer: accepts an item, runs the iterative units, hands off a result.
// ----------------------------------------------------------------------------
`default_nettype none

module agsc_ctrl
  import agsc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic out_busy,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ROUTE = 7'b0000010,
    S_SQRT  = 7'b0000100,
    S_DIVX  = 7'b0001000,
    S_AVG   = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   go_r, go_nxt;
  logic [1:0] axis_r, axis_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    go_nxt    = 1'b0;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.op    = OP_LOAD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_ROUTE;
        end
      end
      S_ROUTE: begin
        if (sts.mode) begin
          axis_nxt  = 2'd0;
          cmd.op    = OP_DIV;
          cmd.start = sts.ok;
          state_nxt = sts.ok ? S_DIVX : S_WAIT;
        end else begin
          cmd.op    = OP_SQRT;
          cmd.start = sts.ok;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op   = OP_SQRT;
        cmd.step = 1'b1;
        if (!sts.busy) begin
          cmd.accum = 1'b1;
          if (sts.last_calib) begin
            // The average starts once the last magnitude is in the sum.
            go_nxt    = 1'b1;
            state_nxt = S_AVG;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_AVG: begin
        cmd.op = OP_AVG;
        if (go_r) begin
          cmd.start = 1'b1;
        end else begin
          cmd.step = 1'b1;
          if (!sts.busy) begin
            cmd.finish_calib = 1'b1;
            state_nxt        = S_WAIT;
          end
        end
      end
      S_DIVX: begin
        cmd.op   = OP_DIV;
        cmd.step = 1'b1;
        if (!sts.busy) begin
          cmd.accum = 1'b1;
          if (axis_r == 2'd2) begin
            state_nxt = S_WAIT;
          end else begin
            cmd.step  = 1'b0;
            cmd.start = 1'b1;
            axis_nxt  = axis_r + 2'd1;
          end
        end
      end
      S_WAIT: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
      axis_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/agsc_dp.sv =====
// ----------------------------------------------------------------------------
// agsc_dp
// Datapath: square-root and restoring-divide unit, accumulators, result.
// ----------------------------------------------------------------------------
`default_nettype none

module agsc_dp
  import agsc_pkg::*;
#(
  parameter int CALIB_SAMPLES = 16,
  parameter int FRACTION_BITS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic               in_mode,
  input  wire logic               in_ok,
  input  wire logic signed [15:0] in_x,
  input  wire logic signed [15:0] in_y,
  input  wire logic signed [15:0] in_z,
  input  wire logic [15:0]        mag_low,
  input  wire logic [15:0]        mag_high,
  input  wire logic [4:0]         min_good,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    out_kind,
  output logic                    out_read_ok,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic signed [15:0]      out_z,
  output logic                    out_accepted,
  output logic [15:0]             out_scale
);

  localparam int IDXW = (CALIB_SAMPLES > 2) ? $clog2(CALIB_SAMPLES) : 1;
  localparam int NW   = 16 + FRACTION_BITS;   // dividend magnitude width
  localparam int QW   = NW;                   // quotient width

  // Captured item.
  logic               mode_r, ok_r;
  logic signed [15:0] ax_r [3];

  // Calibration state.
  logic [15:0]     scale_r;
  logic [19:0]     sum_r;
  logic [4:0]      cnt_r;
  logic [IDXW-1:0] idx_r;

  // Shared iterative unit: sqrt uses rem/res/bit, divide uses rem/res/num/den.
  logic [33:0] rem_r;
  logic [33:0] res_r;
  logic [33:0] bit_r;
  logic [5:0]  cnt_it_r;
  logic        busy_r;
  logic [1:0]  axis_r;
  logic [QW-1:0] num_r;
  logic [16:0] den_r;
  logic        neg_r;

  // Results gathered for the output item.
  logic signed [15:0] g_r [3];
  logic               acc_r;

  // Squares are formed at full width so that no bits are lost.
  logic [33:0] sq_sum;
  logic [31:0] sqx, sqy, sqz;
  assign sqx = 32'($signed(32'(ax_r[0])) * $signed(32'(ax_r[0])));
  assign sqy = 32'($signed(32'(ax_r[1])) * $signed(32'(ax_r[1])));
  assign sqz = 32'($signed(32'(ax_r[2])) * $signed(32'(ax_r[2])));

  logic [33:0] trial;
  assign trial = res_r + bit_r;

  // Divide step: shift in next numerator bit, compare against divisor.
  logic [16:0] drem_sh;
  logic [17:0] dsub;
  assign drem_sh = {rem_r[15:0], num_r[QW-1]};
  assign dsub    = {1'b0, drem_sh} - {1'b0, den_r};

  // The next division takes the following axis while the current one is stored.
  logic [1:0]         div_axis;
  logic signed [16:0] raw_sel;
  logic [15:0]        mag_abs;
  assign div_axis = (cmd.accum && axis_r != 2'd2) ? axis_r + 2'd1 : axis_r;
  assign raw_sel  = 17'(ax_r[div_axis]);
  assign mag_abs  = raw_sel[16] ? 16'(-raw_sel) : raw_sel[15:0];

  // Signed saturating conversion of the quotient magnitude.
  logic signed [15:0] g_sat;
  always_comb begin
    if (neg_r) begin
      g_sat = (res_r[QW-1:0] > QW'(32768)) ? -16'sd32768 : 16'(-res_r[15:0]);
    end else begin
      g_sat = (res_r[QW-1:0] > QW'(32767)) ? 16'sd32767 : res_r[15:0];
    end
  end

  logic [20:0] sum_add;
  assign sum_add = {1'b0, sum_r} + {4'd0, res_r[16:0]};

  assign sts.mode       = mode_r;
  assign sts.ok         = ok_r;
  assign sts.last_calib = (32'(idx_r) == CALIB_SAMPLES - 1);
  assign sts.busy       = busy_r;

  // Capture and iterative unit.
  always_ff @(posedge clk) begin
    if (cmd.start && cmd.op == OP_LOAD) begin
      mode_r <= in_mode;
      ok_r   <= in_ok;
      ax_r[0] <= in_x;
      ax_r[1] <= in_y;
      ax_r[2] <= in_z;
      axis_r <= 2'd0;
      g_r[0] <= '0;
      g_r[1] <= '0;
      g_r[2] <= '0;
    end
    if (cmd.start && cmd.op == OP_SQRT) begin
      rem_r    <= sq_sum;
      res_r    <= '0;
      bit_r    <= 34'h1 << 32;
      cnt_it_r <= 6'd17;
    end
    if (cmd.start && cmd.op == OP_DIV) begin
      num_r    <= QW'(mag_abs) << FRACTION_BITS;
      neg_r    <= raw_sel[16];
      den_r    <= {1'b0, scale_r};
      rem_r    <= '0;
      res_r    <= '0;
      cnt_it_r <= 6'(QW);
    end
    if (cmd.start && cmd.op == OP_AVG) begin
      num_r    <= QW'(sum_r);
      den_r    <= {12'd0, cnt_r};
      rem_r    <= '0;
      res_r    <= '0;
      cnt_it_r <= 6'(QW);
    end
    if (cmd.step && busy_r) begin
      cnt_it_r <= cnt_it_r - 6'd1;
      if (cmd.op == OP_SQRT) begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end else begin
        num_r <= num_r << 1;
        if (!dsub[17]) begin
          rem_r <= {17'd0, dsub[16:0]};
          res_r <= {res_r[32:0], 1'b1};
        end else begin
          rem_r <= {17'd0, drem_sh};
          res_r <= {res_r[32:0], 1'b0};
        end
      end
    end
    if (cmd.accum && mode_r) begin
      g_r[axis_r] <= g_sat;
      axis_r      <= axis_r + 2'd1;
    end
  end

  assign sq_sum = 34'(sqx) + 34'(sqy) + 34'(sqz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.start && cmd.op != OP_LOAD) begin
      busy_r <= 1'b1;
    end else if (cmd.step && busy_r && cnt_it_r == 6'd1) begin
      busy_r <= 1'b0;
    end
  end

  // Calibration accumulators and scale.
  logic [19:0] avg;
  logic        take;
  assign avg  = res_r[19:0];
  assign take = (cnt_r != 5'd0) && (cnt_r >= min_good) && (avg != 20'd0) &&
                (avg >= 20'(mag_low)) && (avg <= 20'(mag_high));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RST;
      sum_r   <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else if (cmd.finish_calib) begin
      if (take) scale_r <= avg[15:0];
      sum_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
    end else if (cmd.accum && !mode_r) begin
      if (ok_r) begin
        sum_r <= sum_add[20] ? SUM_MAX : sum_add[19:0];
        if (cnt_r != COUNT_MAX) cnt_r <= cnt_r + 5'd1;
      end
      if (!sts.last_calib) idx_r <= idx_r + IDXW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_calib) acc_r <= take;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind     <= !mode_r;
      out_read_ok  <= mode_r & ok_r;
      out_x        <= g_r[0];
      out_y        <= g_r[1];
      out_z        <= g_r[2];
      out_accepted <= !mode_r & acc_r;
      out_scale    <= scale_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/accel_gravity_scale_calibrator.sv =====
// ----------------------------------------------------------------------------
// accel_gravity_scale_calibrator
// Gravity-magnitude scale calibration and measurement scaling of raw samples.
// ----------------------------------------------------------------------------
//  channel  dir  transfer when        payload
//  in_*     in   valid & ready        mode, sample_ok, raw_x/y/z
//  out_*    out  valid & ready        report_kind .. scale_now
//  cfg_*    in   valid & ready        index, data (always ready)
//
//  A measurement runs the bit-serial divider once per axis; a calibration item
//  runs 17 square-root steps, and the last of a round also runs the divider
//  for the average and then gives the report. A failed read skips the
//  iterative units. One item at a time; a result waits in the output
//  register while the next item is worked on, and that item holds before its
//  own output until the register is free. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_gravity_scale_calibrator
  import agsc_pkg::*;
#(
  parameter int CALIB_SAMPLES = 16,
  parameter int FRACTION_BITS = 10
) (
  input wire logic  clk,
  input wire logic  rst_n,
  agsc_in_if.sink   in_ch,
  agsc_out_if.source out_ch,
  agsc_cfg_if.sink  cfg_ch
);

  logic [15:0] mag_low_r, mag_high_r;
  logic [4:0]  min_good_r;
  cmd_t        cmd;
  sts_t        sts;
  logic        in_ready;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_low_r  <= MAG_LOW_RST;
      mag_high_r <= MAG_HIGH_RST;
      min_good_r <= MIN_GOOD_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == 8'(REG_MAG_LOW))  mag_low_r  <= cfg_ch.data[15:0];
      if (cfg_ch.index == 8'(REG_MAG_HIGH)) mag_high_r <= cfg_ch.data[15:0];
      if (cfg_ch.index == 8'(REG_MIN_GOOD)) min_good_r <= cfg_ch.data[4:0];
    end
  end

  assign in_ch.ready = in_ready;

  agsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .out_busy (out_ch.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  agsc_dp #(
    .CALIB_SAMPLES (CALIB_SAMPLES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (in_ch.mode),
    .in_ok        (in_ch.sample_ok),
    .in_x         (in_ch.raw_x),
    .in_y         (in_ch.raw_y),
    .in_z         (in_ch.raw_z),
    .mag_low      (mag_low_r),
    .mag_high     (mag_high_r),
    .min_good     (min_good_r),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_kind     (out_ch.report_kind),
    .out_read_ok  (out_ch.read_ok),
    .out_x        (out_ch.x_g),
    .out_y        (out_ch.y_g),
    .out_z        (out_ch.z_g),
    .out_accepted (out_ch.calib_accepted),
    .out_scale    (out_ch.scale_now)
  );

  // The scale never becomes zero.
  a_scale_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.scale_now != 16'd0)
    else $error("scale is zero");

  // A stalled result stays valid and unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.x_g) &&
    $stable(out_ch.scale_now) && $stable(out_ch.report_kind))
    else $error("stalled result changed");

  // A calibration report carries no read_ok.
  a_report_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.report_kind |-> !out_ch.read_ok)
    else $error("report carries read_ok");

endmodule

`default_nettype wire

// ===== tb/agsc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// agsc_tb_pkg
// Sample and result types used by the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package agsc_tb_pkg;

  typedef struct packed {
    logic               mode;
    logic               sample_ok;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } sample_t;

  typedef struct packed {
    logic               report_kind;
    logic               read_ok;
    logic signed [15:0] x_g;
    logic signed [15:0] y_g;
    logic signed [15:0] z_g;
    logic               calib_accepted;
    logic [15:0]        scale_now;
  } result_t;

endpackage

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the gravity scale calibrator against its own prediction of the
// scale, the calibration reports and the scaled measurements, with random
// idling on both channels, a long output stall and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import agsc_pkg::*;
  import agsc_tb_pkg::*;

  localparam int CALIB_N   = 16;
  localparam int FRAC_BITS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  agsc_in_if  in_ch ();
  agsc_out_if out_ch ();
  agsc_cfg_if cfg_ch ();

  accel_gravity_scale_calibrator uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always #1 clk = ~clk;

  // Predicted calibrator state.
  logic [15:0] pred_mag_low, pred_mag_high, pred_scale;
  logic [4:0]  pred_min_good, pred_good;
  logic [19:0] pred_sum;
  int          pred_index;

  result_t expected_results[$];
  int      fail_count = 0;
  int      result_count = 0;
  int      report_count = 0;
  int      accepted_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      stall_cycles = 0;

  // Integer floor square root by the digit-by-digit method.
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // One axis in fixed-point g, truncated toward zero and saturated.
  function automatic logic [15:0] axis_to_g(logic signed [15:0] raw);
    longint q;
    q = (longint'(raw) * (longint'(1) << FRAC_BITS)) / longint'(pred_scale);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Updates the predicted state for one accepted sample and queues any result.
  task automatic predict_sample(sample_t s);
    result_t r;
    longint  x, y, z;
    longint unsigned sq, acc;
    logic [19:0] avg;
    r = '0;
    if (s.mode) begin
      r.read_ok = s.sample_ok;
      if (s.sample_ok) begin
        r.x_g = axis_to_g(s.raw_x);
        r.y_g = axis_to_g(s.raw_y);
        r.z_g = axis_to_g(s.raw_z);
      end
      r.scale_now = pred_scale;
      expected_results.push_back(r);
      return;
    end
    if (s.sample_ok) begin
      x = s.raw_x; y = s.raw_y; z = s.raw_z;
      sq = x * x + y * y + z * z;
      acc = longint'(pred_sum) + isqrt(sq);
      pred_sum = (acc > 64'hFFFFF) ? SUM_MAX : acc[19:0];
      if (pred_good < COUNT_MAX) pred_good++;
    end
    if (pred_index + 1 < CALIB_N) begin
      pred_index++;
      return;
    end
    if (pred_good != 0 && pred_good >= pred_min_good) begin
      avg = pred_sum / pred_good;
      if (avg != 0 && avg >= pred_mag_low && avg <= pred_mag_high) begin
        pred_scale = avg[15:0];
        r.calib_accepted = 1'b1;
      end
    end
    pred_sum = '0;
    pred_good = '0;
    pred_index = 0;
    r.report_kind = 1'b1;
    r.scale_now = pred_scale;
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Sends one sample with random idling before it, then predicts it.
  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.mode      = s.mode;
    in_ch.sample_ok = s.sample_ok;
    in_ch.raw_x     = s.raw_x;
    in_ch.raw_y     = s.raw_y;
    in_ch.raw_z     = s.raw_z;
    do @(posedge clk); while (!in_ch.ready);
    predict_sample(s);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Writes one register while the block is idle.
  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_MAG_LOW) pred_mag_low = value[15:0];
    else if (idx == REG_MAG_HIGH) pred_mag_high = value[15:0];
    else if (idx == REG_MIN_GOOD) pred_min_good = value[4:0];
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Waits until every expected result has arrived and the block has settled.
  task automatic drain_results();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic sample_t rand_sample(logic mode, logic ok);
    sample_t s;
    s.mode = mode;
    s.sample_ok = ok;
    s.raw_x = 16'($urandom);
    s.raw_y = 16'($urandom);
    s.raw_z = 16'($urandom);
    return s;
  endfunction

  // A calibration sample of roughly the given magnitude on the z axis, random sign.
  function automatic sample_t near_sample(int mag, logic ok);
    sample_t s;
    int spread;
    s = rand_sample(1'b0, ok);
    spread = mag / 8 + 1;
    s.raw_x = 16'($urandom_range(2 * spread) - spread);
    s.raw_y = 16'($urandom_range(2 * spread) - spread);
    s.raw_z = 16'(mag);
    if ($urandom_range(1)) s.raw_z = 16'(-mag);
    return s;
  endfunction

  // One full calibration round around a magnitude, with some failed reads.
  task automatic calib_round(int mag, int fail_pct);
    for (int i = 0; i < CALIB_N; i++)
      send_sample(near_sample(mag, $urandom_range(99) >= fail_pct));
  endtask

  // Receiver: random ready, optional long stall, compare with oldest prediction.
  initial begin
    result_t got, want;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_cycles > 0) begin
        out_ch.ready <= 1'b0;
        stall_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.report_kind, out_ch.read_ok, out_ch.x_g, out_ch.y_g, out_ch.z_g,
                out_ch.calib_accepted, out_ch.scale_now};
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result kind", got.report_kind, -1);
        end else begin
          want = expected_results.pop_front();
          if (want.report_kind) report_count++;
          if (want.calib_accepted) accepted_count++;
          if (got.report_kind != want.report_kind)
            report_mismatch("report_kind", got.report_kind, want.report_kind);
          if (got.read_ok != want.read_ok)
            report_mismatch("read_ok", got.read_ok, want.read_ok);
          if (got.x_g != want.x_g) report_mismatch("x_g", got.x_g, want.x_g);
          if (got.y_g != want.y_g) report_mismatch("y_g", got.y_g, want.y_g);
          if (got.z_g != want.z_g) report_mismatch("z_g", got.z_g, want.z_g);
          if (got.calib_accepted != want.calib_accepted)
            report_mismatch("calib_accepted", got.calib_accepted, want.calib_accepted);
          if (got.scale_now != want.scale_now)
            report_mismatch("scale_now", got.scale_now, want.scale_now);
        end
      end
    end
  end

  // Extremes of the axes, failed reads and measurement at the reset scale.
  task automatic test_directed();
    sample_t s;
    logic signed [15:0] ext[4] = '{16'sh7FFF, -16'sh8000, 16'sd0, -16'sd1};
    foreach (ext[i]) begin
      s = '{1'b1, 1'b1, ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]};
      send_sample(s);
    end
    send_sample('{1'b1, 1'b0, 16'sh7FFF, -16'sh8000, 16'sd5});
    // Calibration at full scale: the average is out of window and rejected.
    for (int i = 0; i < CALIB_N; i++)
      send_sample('{1'b0, 1'b1, -16'sh8000, -16'sh8000, -16'sh8000});
    send_sample('{1'b1, 1'b1, 16'sh7FFF, -16'sh8000, 16'sd1});
    drain_results();
  endtask

  // Rounds with no good reads, too few, all zero, and a small accepted scale.
  task automatic test_calibration_edges();
    for (int i = 0; i < CALIB_N; i++) send_sample(rand_sample(1'b0, 1'b0));
    calib_round(2000, 70);
    drain_results();
    write_reg(REG_MAG_LOW, 0);
    write_reg(REG_MIN_GOOD, 1);
    for (int i = 0; i < CALIB_N; i++)
      send_sample('{1'b0, (i == 3), 16'sd0, 16'sd0, 16'sd0});
    send_sample('{1'b0, 1'b1, 16'sd1, 16'sd0, 16'sd0});
    for (int i = 1; i < CALIB_N; i++) send_sample(rand_sample(1'b0, 1'b0));
    // A scale of one saturates every nonzero axis.
    send_sample('{1'b1, 1'b1, 16'sd40, -16'sd40, 16'sd0});
    drain_results();
    write_reg(REG_MAG_HIGH, 16'hFFFF);
    write_reg(REG_MIN_GOOD, 16);
    for (int i = 0; i < CALIB_N; i++)
      send_sample('{1'b0, 1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    send_sample(rand_sample(1'b1, 1'b1));
    drain_results();
    // Out-of-range index is ignored; wide data is masked.
    write_reg(8'd3, 32'hFFFF_FFFF);
    write_reg(REG_MIN_GOOD, 32'hFFFF_FFE4);
    drain_results();
  endtask

  // Random mixture of calibration rounds and measurements under one setting.
  task automatic test_random(int n_items);
    int sent, mag;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 35) begin
        mag = $urandom_range(99) < 80 ? $urandom_range(25000, 500) : $urandom_range(32767);
        calib_round(mag, $urandom_range(40));
        sent += CALIB_N;
      end else if ($urandom_range(99) < 10) begin
        send_sample(rand_sample(1'b0, 1'($urandom_range(1))));
        sent++;
      end else begin
        send_sample(rand_sample(1'b1, $urandom_range(99) < 85));
        sent++;
      end
    end
    drain_results();
  endtask

  task automatic test_settings();
    write_reg(REG_MAG_LOW, 1000);
    write_reg(REG_MAG_HIGH, 30000);
    write_reg(REG_MIN_GOOD, 8);
    send_idle_pct = 22; recv_idle_pct = 58;
    test_random(450);
    write_reg(REG_MAG_LOW, 3000);
    write_reg(REG_MAG_HIGH, 12000);
    write_reg(REG_MIN_GOOD, 14);
    send_idle_pct = 58; recv_idle_pct = 22;
    test_random(450);
    write_reg(REG_MAG_LOW, 0);
    write_reg(REG_MAG_HIGH, 16'hFFFF);
    write_reg(REG_MIN_GOOD, 1);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(450);
  endtask

  // Long output stall while samples keep coming, then a full pause.
  task automatic test_backpressure();
    stall_cycles = 600;
    for (int i = 0; i < 12; i++) send_sample(rand_sample(1'b1, 1'b1));
    drain_results();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.sample_ok = 1'b0;
    in_ch.raw_x = '0;
    in_ch.raw_y = '0;
    in_ch.raw_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    pred_mag_low = MAG_LOW_RST;
    pred_mag_high = MAG_HIGH_RST;
    pred_min_good = MIN_GOOD_RST;
    pred_scale = SCALE_RST;
    pred_sum = '0;
    pred_good = '0;
    pred_index = 0;
    send_idle_pct = 22;
    recv_idle_pct = 58;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_calibration_edges();
    test_backpressure();
    test_settings();
    drain_results();
    $display("covered %0d results, %0d calibration reports, %0d scales taken",
             result_count, report_count, accepted_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/agsc_pkg.sv
rtl/core/agsc_if.sv
rtl/core/agsc_ctrl.sv
rtl/core/agsc_dp.sv
rtl/core/accel_gravity_scale_calibrator.sv
tb/agsc_tb_pkg.sv
tb/testbench.sv
